[rtl/core/mcbk_pkg.sv]
// ----------------------------------------------------------------------------
// mcbk_pkg: shared types for the Morse beacon keyer
// Request and result payloads, control store, symbol and code tables.
// ----------------------------------------------------------------------------
package mcbk_pkg;

	localparam int TEXT_CHARS = 8;            // characters held in the text register
	localparam logic [7:0] CASE_FOLD = 8'd32; // lower to upper case distance

	// configuration register indexes
	localparam logic [2:0] CFG_DOT_LENGTH    = 3'd0;
	localparam logic [2:0] CFG_ID_INTERVAL   = 3'd1;
	localparam logic [2:0] CFG_FIRST_DELAY   = 3'd2;
	localparam logic [2:0] CFG_CALLSIGN_TEXT = 3'd3;
	localparam logic [2:0] CFG_CALLSIGN_LEN  = 3'd4;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		logic        radio_enabled;
	} cmd_t;

	typedef struct packed {
		logic key_on;
		logic keying_active;
		logic id_complete;
	} key_t;

	typedef enum logic [1:0] {
		GAP_TONE   = 2'd0,
		GAP_ELEM   = 2'd1,
		GAP_LETTER = 2'd2
	} gap_t;

	// datapath operations
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_LATCH,
		ACT_SCAN_STEP,
		ACT_FIRST_CHAR,
		ACT_BEGIN_TONE,
		ACT_SCHED_ID,
		ACT_TONE_OFF,
		ACT_LETTER_GAP,
		ACT_ID_DONE,
		ACT_ELEM_GAP,
		ACT_ELEM_ADV,
		ACT_ARM,
		ACT_RADIO_OFF,
		ACT_EMIT
	} act_t;

	// branch conditions
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_CMD,
		COND_IS_START,
		COND_NOT_ARMED,
		COND_RADIO_LOW,
		COND_SENDING,
		COND_START_WAIT,
		COND_SCAN_END,
		COND_SCAN_MISS,
		COND_SEG_WAIT,
		COND_IN_GAP,
		COND_MORE_ELEM,
		COND_OUT_BUSY
	} cond_t;

	typedef logic [4:0] upc_t;

	localparam upc_t UPC_FETCH      = 5'd0;
	localparam upc_t UPC_IS_START   = 5'd1;
	localparam upc_t UPC_ARMED      = 5'd2;
	localparam upc_t UPC_RADIO      = 5'd3;
	localparam upc_t UPC_BUSY       = 5'd4;
	localparam upc_t UPC_DUE        = 5'd5;
	localparam upc_t UPC_LATCH      = 5'd6;
	localparam upc_t UPC_SCAN0_END  = 5'd7;
	localparam upc_t UPC_SCAN0_STEP = 5'd8;
	localparam upc_t UPC_FOUND      = 5'd9;
	localparam upc_t UPC_TONE       = 5'd10;
	localparam upc_t UPC_NO_CHARS   = 5'd11;
	localparam upc_t UPC_SEG        = 5'd12;
	localparam upc_t UPC_GAP_CHK    = 5'd13;
	localparam upc_t UPC_TONE_OFF   = 5'd14;
	localparam upc_t UPC_SCAN1_END  = 5'd15;
	localparam upc_t UPC_SCAN1_STEP = 5'd16;
	localparam upc_t UPC_LETTER_GAP = 5'd17;
	localparam upc_t UPC_LAST       = 5'd18;
	localparam upc_t UPC_ELEM_GAP   = 5'd19;
	localparam upc_t UPC_GAP_END    = 5'd20;
	localparam upc_t UPC_START      = 5'd21;
	localparam upc_t UPC_OFF        = 5'd22;
	localparam upc_t UPC_EMIT       = 5'd31; // falls through to FETCH on wrap

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} ucode_t;

	// condition flags from the datapath
	typedef struct packed {
		logic no_cmd;
		logic is_start;
		logic not_armed;
		logic radio_low;
		logic sending;
		logic start_wait;
		logic scan_end;
		logic scan_miss;
		logic seg_wait;
		logic in_gap;
		logic more_elem;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] idx;
	} sym_t;

	typedef struct packed {
		logic [2:0] len;
		logic [4:0] dash; // bit k set: element k is a dash
	} code_t;

	function automatic ucode_t ucode(input upc_t a);
		ucode_t w;
		unique case (a)
			UPC_FETCH:      w = '{ACT_LOAD,       COND_NO_CMD,     UPC_FETCH};
			UPC_IS_START:   w = '{ACT_NONE,       COND_IS_START,   UPC_START};
			UPC_ARMED:      w = '{ACT_NONE,       COND_NOT_ARMED,  UPC_EMIT};
			UPC_RADIO:      w = '{ACT_NONE,       COND_RADIO_LOW,  UPC_OFF};
			UPC_BUSY:       w = '{ACT_NONE,       COND_SENDING,    UPC_SEG};
			UPC_DUE:        w = '{ACT_NONE,       COND_START_WAIT, UPC_EMIT};
			UPC_LATCH:      w = '{ACT_LATCH,      COND_NEVER,      UPC_FETCH};
			UPC_SCAN0_END:  w = '{ACT_NONE,       COND_SCAN_END,   UPC_NO_CHARS};
			UPC_SCAN0_STEP: w = '{ACT_SCAN_STEP,  COND_SCAN_MISS,  UPC_SCAN0_END};
			UPC_FOUND:      w = '{ACT_FIRST_CHAR, COND_NEVER,      UPC_FETCH};
			UPC_TONE:       w = '{ACT_BEGIN_TONE, COND_ALWAYS,     UPC_EMIT};
			UPC_NO_CHARS:   w = '{ACT_SCHED_ID,   COND_ALWAYS,     UPC_EMIT};
			UPC_SEG:        w = '{ACT_NONE,       COND_SEG_WAIT,   UPC_EMIT};
			UPC_GAP_CHK:    w = '{ACT_NONE,       COND_IN_GAP,     UPC_GAP_END};
			UPC_TONE_OFF:   w = '{ACT_TONE_OFF,   COND_MORE_ELEM,  UPC_ELEM_GAP};
			UPC_SCAN1_END:  w = '{ACT_NONE,       COND_SCAN_END,   UPC_LAST};
			UPC_SCAN1_STEP: w = '{ACT_SCAN_STEP,  COND_SCAN_MISS,  UPC_SCAN1_END};
			UPC_LETTER_GAP: w = '{ACT_LETTER_GAP, COND_ALWAYS,     UPC_EMIT};
			UPC_LAST:       w = '{ACT_ID_DONE,    COND_ALWAYS,     UPC_EMIT};
			UPC_ELEM_GAP:   w = '{ACT_ELEM_GAP,   COND_ALWAYS,     UPC_EMIT};
			UPC_GAP_END:    w = '{ACT_ELEM_ADV,   COND_ALWAYS,     UPC_TONE};
			UPC_START:      w = '{ACT_ARM,        COND_ALWAYS,     UPC_EMIT};
			UPC_OFF:        w = '{ACT_RADIO_OFF,  COND_ALWAYS,     UPC_EMIT};
			UPC_EMIT:       w = '{ACT_EMIT,       COND_OUT_BUSY,   UPC_EMIT};
			default:        w = '{ACT_NONE,       COND_ALWAYS,     UPC_FETCH};
		endcase
		return w;
	endfunction

	// fold case, map A-Z to 0..25 and 0-9 to 26..35
	function automatic sym_t sym_of(input logic [7:0] c);
		logic [7:0] u;
		sym_t       s;
		u = c;
		if (c >= "a" && c <= "z") u = c - CASE_FOLD;
		s.valid = 1'b0;
		s.idx   = '0;
		if (u >= "A" && u <= "Z") begin
			s.valid = 1'b1;
			s.idx   = 6'(u - 8'("A"));
		end else if (u >= "0" && u <= "9") begin
			s.valid = 1'b1;
			s.idx   = 6'(8'd26 + (u - 8'("0")));
		end
		return s;
	endfunction

	function automatic code_t morse_code(input logic [5:0] idx);
		code_t k;
		case (idx)
			6'd0:  k = '{3'd2, 5'b00010}; // A .-
			6'd1:  k = '{3'd4, 5'b00001}; // B
			6'd2:  k = '{3'd4, 5'b00101}; // C
			6'd3:  k = '{3'd3, 5'b00001}; // D
			6'd4:  k = '{3'd1, 5'b00000}; // E
			6'd5:  k = '{3'd4, 5'b00100}; // F
			6'd6:  k = '{3'd3, 5'b00011}; // G
			6'd7:  k = '{3'd4, 5'b00000}; // H
			6'd8:  k = '{3'd2, 5'b00000}; // I
			6'd9:  k = '{3'd4, 5'b01110}; // J
			6'd10: k = '{3'd3, 5'b00101}; // K
			6'd11: k = '{3'd4, 5'b00010}; // L
			6'd12: k = '{3'd2, 5'b00011}; // M
			6'd13: k = '{3'd2, 5'b00001}; // N
			6'd14: k = '{3'd3, 5'b00111}; // O
			6'd15: k = '{3'd4, 5'b00110}; // P
			6'd16: k = '{3'd4, 5'b01011}; // Q
			6'd17: k = '{3'd3, 5'b00010}; // R
			6'd18: k = '{3'd3, 5'b00000}; // S
			6'd19: k = '{3'd1, 5'b00001}; // T
			6'd20: k = '{3'd3, 5'b00100}; // U
			6'd21: k = '{3'd4, 5'b01000}; // V
			6'd22: k = '{3'd3, 5'b00110}; // W
			6'd23: k = '{3'd4, 5'b01001}; // X
			6'd24: k = '{3'd4, 5'b01101}; // Y
			6'd25: k = '{3'd4, 5'b00011}; // Z
			6'd26: k = '{3'd5, 5'b11111}; // 0 -----
			6'd27: k = '{3'd5, 5'b11110}; // 1
			6'd28: k = '{3'd5, 5'b11100}; // 2
			6'd29: k = '{3'd5, 5'b11000}; // 3
			6'd30: k = '{3'd5, 5'b10000}; // 4
			6'd31: k = '{3'd5, 5'b00000}; // 5
			6'd32: k = '{3'd5, 5'b00001}; // 6
			6'd33: k = '{3'd5, 5'b00011}; // 7
			6'd34: k = '{3'd5, 5'b00111}; // 8
			6'd35: k = '{3'd5, 5'b01111}; // 9
			default: k = '{3'd0, 5'b00000};
		endcase
		return k;
	endfunction

endpackage

[rtl/core/mcbk_useq.sv]
// ----------------------------------------------------------------------------
// mcbk_useq: control sequencer
// Step counter over the control store with one conditional jump per word.
// ----------------------------------------------------------------------------
module mcbk_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  mcbk_pkg::flags_t flags,
	output mcbk_pkg::ucode_t ctl
);

	mcbk_pkg::upc_t upc_q;
	mcbk_pkg::upc_t upc_d;
	logic           take;

	assign ctl = mcbk_pkg::ucode(upc_q);

	always_comb begin
		unique case (ctl.cond)
			mcbk_pkg::COND_NEVER:      take = 1'b0;
			mcbk_pkg::COND_ALWAYS:     take = 1'b1;
			mcbk_pkg::COND_NO_CMD:     take = flags.no_cmd;
			mcbk_pkg::COND_IS_START:   take = flags.is_start;
			mcbk_pkg::COND_NOT_ARMED:  take = flags.not_armed;
			mcbk_pkg::COND_RADIO_LOW:  take = flags.radio_low;
			mcbk_pkg::COND_SENDING:    take = flags.sending;
			mcbk_pkg::COND_START_WAIT: take = flags.start_wait;
			mcbk_pkg::COND_SCAN_END:   take = flags.scan_end;
			mcbk_pkg::COND_SCAN_MISS:  take = flags.scan_miss;
			mcbk_pkg::COND_SEG_WAIT:   take = flags.seg_wait;
			mcbk_pkg::COND_IN_GAP:     take = flags.in_gap;
			mcbk_pkg::COND_MORE_ELEM:  take = flags.more_elem;
			mcbk_pkg::COND_OUT_BUSY:   take = flags.out_busy;
			default:                   take = 1'b0;
		endcase
	end

	// the last word wraps to step zero
	assign upc_d = take ? ctl.target : upc_q + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= mcbk_pkg::UPC_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

[rtl/core/morse_callsign_beacon_keyer_unit.sv]
// ----------------------------------------------------------------------------
// morse_callsign_beacon_keyer_unit: periodic Morse ID keyer
// Keys a callsign as timed tone/gap segments on millisecond tick requests.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  cmd      | in        | cmd_valid/cmd_stall| op, now_ms, radio_enabled
//  key      | out       | key_valid/key_stall| key_on, keying_active, id_complete
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One result per request, loaded after accept once the scans have passed
//  any characters that are not letters or digits; the sequencer then goes
//  back to the fetch step. One request in flight; cmd is taken only at the
//  fetch step. The result waits in an output register; the sequencer holds
//  at its emit step only if that register is still stalled.
//  Async reset clears control and timing state; config takes its defaults.
//
module morse_callsign_beacon_keyer_unit #(
	parameter int MAX_CHARS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  mcbk_pkg::cmd_t cmd,
	// result channel
	output logic           key_valid,
	input  logic           key_stall,
	output mcbk_pkg::key_t key,
	// config write channel
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [63:0]    cfg_data
);

	localparam int CW = $clog2(MAX_CHARS + 1); // cursor width, holds MAX_CHARS

	// config registers
	logic [14:0] dot_q;
	logic [30:0] interval_q;
	logic [30:0] first_q;
	logic [63:0] text_q;
	logic [3:0]  len_q;

	// latched at ID start
	logic [14:0]   lat_dot_q;
	logic [63:0]   lat_text_q;
	logic [CW-1:0] lat_len_q;

	// request held during processing
	logic        op_q;
	logic [31:0] now_q;
	logic        radio_q;

	// keyer state
	logic           armed_q;
	logic           sending_q;
	logic           tone_q;
	logic           done_q;
	logic [31:0]    nst_q;   // next ID start time
	logic [31:0]    seg_q;   // current segment end time
	logic [CW-1:0]  cc_q;    // character cursor
	logic [CW-1:0]  j_q;     // scan cursor
	logic [2:0]     elem_q;
	mcbk_pkg::gap_t gap_q;

	// result register
	logic           key_valid_q;
	mcbk_pkg::key_t key_q;

	mcbk_pkg::ucode_t ctl;
	mcbk_pkg::flags_t flags;

	mcbk_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	// ------------------------------------------------------------------
	// datapath combinational terms
	// ------------------------------------------------------------------
	logic [7:0]        byte_j;
	logic [7:0]        byte_c;
	mcbk_pkg::sym_t    sym_j;
	mcbk_pkg::sym_t    sym_c;
	mcbk_pkg::code_t   code_c;
	logic [2:0]        n_elems;
	logic [7:0]        dash8;
	logic [15:0]       three_dots;
	logic [15:0]       tone_len;
	logic [31:0]       start_diff;
	logic [31:0]       seg_diff;
	logic              key_busy;
	logic [CW-1:0]     lat_len_d;

	// positions past the text register read as NUL, which is skipped
	assign byte_j = (32'(j_q) < 32'(mcbk_pkg::TEXT_CHARS)) ?
		8'(lat_text_q >> {j_q, 3'b000}) : 8'd0;
	assign byte_c = (32'(cc_q) < 32'(mcbk_pkg::TEXT_CHARS)) ?
		8'(lat_text_q >> {cc_q, 3'b000}) : 8'd0;

	assign sym_j   = mcbk_pkg::sym_of(byte_j);
	assign sym_c   = mcbk_pkg::sym_of(byte_c);
	assign code_c  = mcbk_pkg::morse_code(sym_c.idx);
	assign n_elems = sym_c.valid ? code_c.len : 3'd0;
	assign dash8   = sym_c.valid ? {3'b000, code_c.dash} : 8'd0;

	// 3 x dot, kept to 16 bits
	assign three_dots = 16'({2'b00, lat_dot_q} + {1'b0, lat_dot_q, 1'b0});
	assign tone_len   = dash8[elem_q] ? three_dots : {1'b0, lat_dot_q};

	// wrap-safe deadline check: deadline reached when sign bit of diff is 0
	assign start_diff = now_q - nst_q;
	assign seg_diff   = now_q - seg_q;

	assign key_busy = key_valid_q && key_stall;

	assign lat_len_d = ({28'd0, len_q} > 32'(MAX_CHARS)) ? CW'(MAX_CHARS) : CW'(len_q);

	always_comb begin
		flags.no_cmd     = !cmd_valid;
		flags.is_start   = (op_q == mcbk_pkg::OP_START);
		flags.not_armed  = !armed_q;
		flags.radio_low  = !radio_q;
		flags.sending    = sending_q;
		flags.start_wait = start_diff[31];
		flags.scan_end   = !(j_q < lat_len_q);
		flags.scan_miss  = !sym_j.valid;
		flags.seg_wait   = seg_diff[31];
		flags.in_gap     = (gap_q != mcbk_pkg::GAP_TONE);
		flags.more_elem  = ({1'b0, elem_q} + 4'd1) < {1'b0, n_elems};
		flags.out_busy   = key_busy;
	end

	// request is taken only at the fetch step
	assign cmd_stall = (ctl.act != mcbk_pkg::ACT_LOAD);
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// config registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q      <= 15'd60;
			interval_q <= 31'd600000;
			first_q    <= 31'd10000;
			text_q     <= '0;
			len_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcbk_pkg::CFG_DOT_LENGTH:    dot_q      <= cfg_data[14:0];
				mcbk_pkg::CFG_ID_INTERVAL:   interval_q <= cfg_data[30:0];
				mcbk_pkg::CFG_FIRST_DELAY:   first_q    <= cfg_data[30:0];
				mcbk_pkg::CFG_CALLSIGN_TEXT: text_q     <= cfg_data;
				mcbk_pkg::CFG_CALLSIGN_LEN:  len_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers, one operation per control word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= mcbk_pkg::OP_TICK;
			now_q      <= '0;
			radio_q    <= 1'b0;
			lat_dot_q  <= '0;
			lat_text_q <= '0;
			lat_len_q  <= '0;
			armed_q    <= 1'b0;
			sending_q  <= 1'b0;
			tone_q     <= 1'b0;
			done_q     <= 1'b0;
			nst_q      <= '0;
			seg_q      <= '0;
			cc_q       <= '0;
			j_q        <= '0;
			elem_q     <= '0;
			gap_q      <= mcbk_pkg::GAP_TONE;
		end else begin
			unique case (ctl.act)
				mcbk_pkg::ACT_LOAD: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						now_q   <= cmd.now_ms;
						radio_q <= cmd.radio_enabled;
						done_q  <= 1'b0;
					end
				end
				mcbk_pkg::ACT_LATCH: begin
					lat_dot_q  <= dot_q;
					lat_text_q <= text_q;
					lat_len_q  <= lat_len_d;
					j_q        <= '0;
				end
				mcbk_pkg::ACT_SCAN_STEP: begin
					if (!sym_j.valid) j_q <= j_q + CW'(1);
				end
				mcbk_pkg::ACT_FIRST_CHAR: begin
					sending_q <= 1'b1;
					cc_q      <= j_q;
					elem_q    <= '0;
				end
				mcbk_pkg::ACT_BEGIN_TONE: begin
					gap_q  <= mcbk_pkg::GAP_TONE;
					tone_q <= 1'b1;
					seg_q  <= now_q + {16'd0, tone_len};
				end
				mcbk_pkg::ACT_SCHED_ID: begin
					nst_q <= now_q + {1'b0, interval_q};
				end
				mcbk_pkg::ACT_TONE_OFF: begin
					tone_q <= 1'b0;
					j_q    <= cc_q + CW'(1);
				end
				mcbk_pkg::ACT_LETTER_GAP: begin
					gap_q  <= mcbk_pkg::GAP_LETTER;
					cc_q   <= j_q;
					elem_q <= '0;
					seg_q  <= now_q + {16'd0, three_dots};
				end
				mcbk_pkg::ACT_ID_DONE: begin
					sending_q <= 1'b0;
					gap_q     <= mcbk_pkg::GAP_TONE;
					nst_q     <= now_q + {1'b0, interval_q};
					done_q    <= 1'b1;
				end
				mcbk_pkg::ACT_ELEM_GAP: begin
					gap_q <= mcbk_pkg::GAP_ELEM;
					seg_q <= now_q + {17'd0, lat_dot_q};
				end
				mcbk_pkg::ACT_ELEM_ADV: begin
					// letter gap ends on element zero of the new character
					if (gap_q == mcbk_pkg::GAP_ELEM) elem_q <= elem_q + 3'd1;
				end
				mcbk_pkg::ACT_ARM: begin
					armed_q   <= 1'b1;
					sending_q <= 1'b0;
					tone_q    <= 1'b0;
					nst_q     <= now_q + {1'b0, first_q};
				end
				mcbk_pkg::ACT_RADIO_OFF: begin
					sending_q <= 1'b0;
					tone_q    <= 1'b0;
					nst_q     <= now_q + {1'b0, first_q};
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (ctl.act == mcbk_pkg::ACT_EMIT && !key_busy) begin
			key_valid_q <= 1'b1;
		end else if (!key_stall) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == mcbk_pkg::ACT_EMIT && !key_busy) begin
			key_q.key_on        <= tone_q && sending_q;
			key_q.keying_active <= sending_q;
			key_q.id_complete   <= done_q;
		end
	end

	assign key_valid = key_valid_q;
	assign key       = key_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("request accepted while previous one in progress");

	a_tone_needs_id: assert property (@(posedge clk) disable iff (!arst_n)
		tone_q |-> sending_q)
		else $error("tone keyed outside an ID");

	a_gap_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(gap_q != mcbk_pkg::GAP_TONE) |-> !tone_q)
		else $error("tone on during a gap segment");

	a_done_ends_id: assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && key.id_complete) |-> (!key.keying_active && !key.key_on))
		else $error("ID completion reported while still keying");

endmodule
